// File: hdl/tbgg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the three-body gravity gradient pipeline.
// No dependencies.
package tbgg_pkg;

    localparam int MAG_W   = 35;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int UNIT_W  = 31;
    localparam int A_W     = 50;
    localparam int ENTRY_W = 48;
    localparam logic [A_W-1:0] A_LIMIT = {A_W{1'b1}};
    localparam logic [30:0] UNIT_ONE = 31'h4000_0000;

    typedef struct packed {
        logic          valid;
        logic          have;
        logic          clip;
        logic [A_W-1:0] acoef;
        logic [2:0]    neg;
        logic [UNIT_W-1:0] u0;
        logic [UNIT_W-1:0] u1;
        logic [UNIT_W-1:0] u2;
    } t_body;

endpackage

// File: hdl/tbgg_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tbgg_pkg.
module tbgg_div import tbgg_pkg::*; #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32,
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic [NUM_W:0]   r_valid;
    logic [NUM_W-1:0] r_num [NUM_W+1];
    logic [DEN_W:0]   r_rem [NUM_W+1];
    logic [DEN_W-1:0] r_den [NUM_W+1];
    logic [TAG_W-1:0] r_tag [NUM_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[NUM_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_num[0] <= i_num;
        r_rem[0] <= '0;
        r_den[0] <= i_den;
        r_tag[0] <= i_tag;
    end

    // Each stage shifts in one dividend bit and subtracts when it fits.
    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W+1:0] w_trial;
        logic [DEN_W+1:0] w_diff;
        assign w_trial = {r_rem[s], r_num[s][NUM_W-1]};
        assign w_diff  = w_trial - {2'b00, r_den[s]};
        always_ff @(posedge i_clk) begin
            r_den[s+1] <= r_den[s];
            r_tag[s+1] <= r_tag[s];
            if (!w_diff[DEN_W+1]) begin
                r_rem[s+1] <= w_diff[DEN_W:0];
                r_num[s+1] <= {r_num[s][NUM_W-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= w_trial[DEN_W:0];
                r_num[s+1] <= {r_num[s][NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_valid[NUM_W];
    assign o_quo   = r_num[NUM_W];
    assign o_tag   = r_tag[NUM_W];

endmodule

// File: hdl/tbgg_body.sv
`timescale 1ns / 1ps
// Per-primary pipeline: normalize, square-sum, root, unit vector, a coefficient.
// Depends on tbgg_pkg and tbgg_div.
module tbgg_body import tbgg_pkg::*; #(
    parameter int OUT_FRAC_BITS = 32,
    parameter int OFF_W = 38
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic signed [OFF_W-1:0] i_off_x,
    input  logic signed [OFF_W-1:0] i_off_y,
    input  logic signed [OFF_W-1:0] i_off_z,
    input  logic [32:0]       i_mass,
    output t_body             o_body
);

    localparam int RT = 32;   // root stages
    // Stage A: magnitudes and signs.
    logic        r_a_v;
    logic [OFF_W-1:0] r_a_m [3];
    logic [2:0]  r_a_neg;
    logic [32:0] r_a_mass;
    logic [OFF_W-1:0] w_mag [3];
    logic [OFF_W-1:0] w_big;
    logic signed [OFF_W-1:0] w_off [3];

    assign w_off[0] = i_off_x;
    assign w_off[1] = i_off_y;
    assign w_off[2] = i_off_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = w_off[i][OFF_W-1] ? OFF_W'(-w_off[i]) : OFF_W'(w_off[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else r_a_v <= i_valid;
        for (int i = 0; i < 3; i++) begin
            r_a_m[i]   <= w_mag[i];
            r_a_neg[i] <= w_off[i][OFF_W-1];
        end
        r_a_mass <= i_mass;
    end

    // Stage B: exponent and shift so the top bit lands at bit 30.
    always_comb begin
        w_big = r_a_m[0] | r_a_m[1] | r_a_m[2];
    end

    logic [5:0] w_n;
    always_comb begin
        w_n = '0;
        for (int b = 0; b < OFF_W; b++) begin
            if (w_big[b]) w_n = 6'(b + 1);
        end
    end

    logic              r_b_v;
    logic              r_b_have;
    logic signed [6:0] r_b_e;
    logic [30:0]       r_b_m [3];
    logic [2:0]        r_b_neg;
    logic [32:0]       r_b_mass;
    logic signed [6:0] w_e;
    assign w_e = $signed({1'b0, w_n}) - 7'sd31;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v <= 1'b0;
        else r_b_v <= r_a_v;
        r_b_have <= (w_big != '0);
        r_b_e    <= w_e;
        r_b_neg  <= r_a_neg;
        r_b_mass <= r_a_mass;
        for (int i = 0; i < 3; i++) begin
            if (w_e > 0) r_b_m[i] <= 31'(r_a_m[i] >> w_e);
            else         r_b_m[i] <= 31'(r_a_m[i] << (-w_e));
        end
    end

    // Stage C: squares.
    logic        r_c_v;
    logic [61:0] r_c_sq [3];
    logic [30:0] r_c_m [3];
    logic        r_c_have;
    logic signed [6:0] r_c_e;
    logic [2:0]  r_c_neg;
    logic [32:0] r_c_mass;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_v <= 1'b0;
        else r_c_v <= r_b_v;
        for (int i = 0; i < 3; i++) begin
            r_c_sq[i] <= 62'(r_b_m[i]) * 62'(r_b_m[i]);
        end
        r_c_m <= r_b_m; r_c_have <= r_b_have; r_c_e <= r_b_e;
        r_c_neg <= r_b_neg; r_c_mass <= r_b_mass;
    end

    // Stage D: sum.
    logic        r_d_v;
    logic [63:0] r_d_sum;
    logic [30:0] r_d_m [3];
    logic        r_d_have;
    logic signed [6:0] r_d_e;
    logic [2:0]  r_d_neg;
    logic [32:0] r_d_mass;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_v <= 1'b0;
        else r_d_v <= r_c_v;
        r_d_sum <= 64'(r_c_sq[0]) + 64'(r_c_sq[1]) + 64'(r_c_sq[2]);
        r_d_m <= r_c_m; r_d_have <= r_c_have; r_d_e <= r_c_e;
        r_d_neg <= r_c_neg; r_d_mass <= r_c_mass;
    end

    // Square root: one result bit per stage.
    logic [RT:0]   r_s_v;
    logic [63:0]   r_s_rad  [RT+1];
    logic [33:0]   r_s_rem  [RT+1];
    logic [31:0]   r_s_root [RT+1];
    logic [30:0]   r_s_m0 [RT+1];
    logic [30:0]   r_s_m1 [RT+1];
    logic [30:0]   r_s_m2 [RT+1];
    logic [RT:0]   r_s_have;
    logic signed [6:0] r_s_e [RT+1];
    logic [2:0]    r_s_neg [RT+1];
    logic [32:0]   r_s_mass [RT+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s_v <= '0;
        else r_s_v <= {r_s_v[RT-1:0], r_d_v};
    end
    always_ff @(posedge i_clk) begin
        r_s_rad[0] <= r_d_sum; r_s_rem[0] <= '0; r_s_root[0] <= '0;
        r_s_m0[0] <= r_d_m[0]; r_s_m1[0] <= r_d_m[1]; r_s_m2[0] <= r_d_m[2];
        r_s_have[0] <= r_d_have; r_s_e[0] <= r_d_e; r_s_neg[0] <= r_d_neg;
        r_s_mass[0] <= r_d_mass;
    end
    for (genvar s = 0; s < RT; s++) begin : g_root
        logic [35:0] w_trial;
        logic [35:0] w_sub;
        logic [35:0] w_diff;
        assign w_trial = {r_s_rem[s], r_s_rad[s][63:62]};
        assign w_sub   = {2'b00, r_s_root[s], 2'b01};
        assign w_diff  = w_trial - w_sub;
        always_ff @(posedge i_clk) begin
            r_s_rad[s+1] <= {r_s_rad[s][61:0], 2'b00};
            if (w_trial >= w_sub) begin
                r_s_rem[s+1]  <= w_diff[33:0];
                r_s_root[s+1] <= {r_s_root[s][30:0], 1'b1};
            end else begin
                r_s_rem[s+1]  <= w_trial[33:0];
                r_s_root[s+1] <= {r_s_root[s][30:0], 1'b0};
            end
            r_s_m0[s+1] <= r_s_m0[s]; r_s_m1[s+1] <= r_s_m1[s];
            r_s_m2[s+1] <= r_s_m2[s];
            r_s_have[s+1] <= r_s_have[s]; r_s_e[s+1] <= r_s_e[s];
            r_s_neg[s+1] <= r_s_neg[s]; r_s_mass[s+1] <= r_s_mass[s];
        end
    end

    logic [31:0] w_rr;
    assign w_rr = (r_s_root[RT] == '0) ? 32'd1 : r_s_root[RT];

    // Three unit-vector dividers and the first mass division run in parallel.
    // Tag layout: have at bit 42, e at 41:35, signs at 34:32, root at 31:0.
    localparam int TAG_W = 1 + 7 + 3 + 32;
    logic [TAG_W-1:0] w_tag_in;
    assign w_tag_in = {r_s_have[RT], r_s_e[RT], r_s_neg[RT], w_rr};

    logic        w_u_v [3];
    logic [60:0] w_u_q [3];
    logic [60:0] w_u_num [3];
    logic [TAG_W-1:0] w_u_tag [3];
    assign w_u_num[0] = {r_s_m0[RT], 30'd0};
    assign w_u_num[1] = {r_s_m1[RT], 30'd0};
    assign w_u_num[2] = {r_s_m2[RT], 30'd0};

    for (genvar i = 0; i < 3; i++) begin : g_unit
        tbgg_div #(.NUM_W(61), .DEN_W(32), .TAG_W(TAG_W)) u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_s_v[RT]),
            .i_num(w_u_num[i]), .i_den(w_rr), .i_tag(w_tag_in),
            .o_valid(w_u_v[i]), .o_quo(w_u_q[i]), .o_tag(w_u_tag[i])
        );
    end

    // q chain: mass*2^31/r, *2^30/r, *2^30/r. Each quotient fits in 64 bits.
    logic        w_q1_v, w_q2_v, w_q3_v;
    logic [63:0] w_q1, w_q2, w_q3;
    logic [TAG_W-1:0] w_q1_t, w_q2_t, w_q3_t;

    tbgg_div #(.NUM_W(64), .DEN_W(32), .TAG_W(TAG_W)) u_q1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_s_v[RT]),
        .i_num({r_s_mass[RT], 31'd0}), .i_den(w_rr), .i_tag(w_tag_in),
        .o_valid(w_q1_v), .o_quo(w_q1), .o_tag(w_q1_t)
    );
    tbgg_div #(.NUM_W(64), .DEN_W(32), .TAG_W(TAG_W)) u_q2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_q1_v),
        .i_num({w_q1[33:0], 30'd0}), .i_den(w_q1_t[31:0]), .i_tag(w_q1_t),
        .o_valid(w_q2_v), .o_quo(w_q2), .o_tag(w_q2_t)
    );
    tbgg_div #(.NUM_W(64), .DEN_W(32), .TAG_W(TAG_W)) u_q3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_q2_v),
        .i_num({w_q2[33:0], 30'd0}), .i_den(w_q2_t[31:0]), .i_tag(w_q2_t),
        .o_valid(w_q3_v), .o_quo(w_q3), .o_tag(w_q3_t)
    );

    // The unit dividers are shorter than the q chain, so the unit vector
    // waits in the r_ud delay line to meet the matching coefficient.
    localparam int UD = 3 * 65 - 62;
    logic [3*UNIT_W-1:0] r_ud [UD];
    always_ff @(posedge i_clk) begin
        r_ud[0] <= {w_u_q[2][30:0], w_u_q[1][30:0], w_u_q[0][30:0]};
        for (int k = 1; k < UD; k++) r_ud[k] <= r_ud[k-1];
    end

    // Scale q into a with clipping.
    logic signed [8:0] w_sh;
    logic [49:0]       w_a;
    logic              w_aclip;
    assign w_sh = 9'(OUT_FRAC_BITS - 27) - 9'(3 * $signed(w_q3_t[41:35]));
    always_comb begin
        w_aclip = 1'b0;
        if (w_sh < 0) begin
            w_a = 50'(w_q3 >> (-w_sh));
        end else if (w_q3 == '0) begin
            w_a = '0;
        end else if (w_sh >= 50 || w_q3 > 64'(A_LIMIT >> w_sh)) begin
            w_a = A_LIMIT;
            w_aclip = 1'b1;
        end else begin
            w_a = 50'(w_q3 << w_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_body.valid <= 1'b0;
        else o_body.valid <= w_q3_v;
        o_body.have  <= w_q3_t[42];
        o_body.clip  <= w_q3_t[42] ? w_aclip : 1'b1;
        o_body.acoef <= w_a;
        o_body.neg   <= w_q3_t[34:32];
        o_body.u0    <= r_ud[UD-1][30:0];
        o_body.u1    <= r_ud[UD-1][61:31];
        o_body.u2    <= r_ud[UD-1][92:62];
    end

endmodule

// File: hdl/tbgg_entry.sv
`timescale 1ns / 1ps
// Combines the two primaries' terms into the six gradient entries.
// Depends on tbgg_pkg.
module tbgg_entry import tbgg_pkg::*; #(
    parameter int OUT_FRAC_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_body              i_b1,
    input  t_body              i_b2,
    output logic               o_valid,
    output logic [6*ENTRY_W-1:0] o_grad,
    output logic               o_sat
);

    localparam int RI [6] = '{0, 0, 0, 1, 1, 2};
    localparam int CI [6] = '{0, 1, 2, 1, 2, 2};

    function automatic logic [30:0] pick(t_body b, int i);
        logic [30:0] r;
        r = (i == 0) ? b.u0 : ((i == 1) ? b.u1 : b.u2);
        return r;
    endfunction

    // Stage 1: factor magnitudes and signs.
    logic        r1_v;
    t_body       r1_b [2];
    logic [31:0] r1_g [2][6];
    logic        r1_fn [2][6];
    always_ff @(posedge i_clk) begin
        logic [61:0] p;
        logic [32:0] fm;
        logic signed [33:0] f;
        if (!i_rst_n) r1_v <= 1'b0;
        else r1_v <= i_b1.valid;
        r1_b[0] <= i_b1;
        r1_b[1] <= i_b2;
        for (int b = 0; b < 2; b++) begin
            for (int k = 0; k < 6; k++) begin
                t_body bb;
                bb = (b == 0) ? i_b1 : i_b2;
                p  = 62'(pick(bb, RI[k])) * 62'(pick(bb, CI[k]));
                fm = 33'((64'(p) * 64'd3) >> 30);
                f  = (bb.neg[RI[k]] != bb.neg[CI[k]]) ? -$signed({1'b0, fm})
                                                       : $signed({1'b0, fm});
                if (RI[k] == CI[k]) f = f - $signed({3'b000, UNIT_ONE});
                r1_fn[b][k] <= f[33];
                r1_g[b][k]  <= f[33] ? 32'(-f) : 32'(f);
            end
        end
    end

    // Stage 2: partial products of a by the factor.
    logic        r2_v;
    logic        r2_have [2];
    logic        r2_clip;
    logic        r2_fn [2][6];
    logic [51:0] r2_hi [2][6];
    logic [61:0] r2_lo [2][6];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else r2_v <= r1_v;
        r2_clip <= r1_b[0].clip | r1_b[1].clip;
        for (int b = 0; b < 2; b++) begin
            r2_have[b] <= r1_b[b].have;
            for (int k = 0; k < 6; k++) begin
                r2_fn[b][k] <= r1_fn[b][k];
                r2_hi[b][k] <= 52'(r1_b[b].acoef[49:30]) * 52'(r1_g[b][k]);
                r2_lo[b][k] <= 62'(r1_b[b].acoef[29:0]) * 62'(r1_g[b][k]);
            end
        end
    end

    // Stage 3: signed terms.
    logic        r3_v;
    logic        r3_clip;
    logic signed [53:0] r3_t [2][6];
    always_ff @(posedge i_clk) begin
        logic [52:0] t;
        if (!i_rst_n) r3_v <= 1'b0;
        else r3_v <= r2_v;
        r3_clip <= r2_clip;
        for (int b = 0; b < 2; b++) begin
            for (int k = 0; k < 6; k++) begin
                t = 53'(r2_hi[b][k]) + 53'(r2_lo[b][k] >> 30);
                if (!r2_have[b]) r3_t[b][k] <= '0;
                else if (r2_fn[b][k]) r3_t[b][k] <= -$signed({1'b0, t});
                else r3_t[b][k] <= $signed({1'b0, t});
            end
        end
    end

    // Stage 4: sum and saturate.
    always_ff @(posedge i_clk) begin
        logic signed [55:0] v;
        logic s;
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= r3_v;
        s = r3_clip;
        for (int k = 0; k < 6; k++) begin
            v = 56'(r3_t[0][k]) + 56'(r3_t[1][k]);
            if (RI[k] == CI[k] && RI[k] < 2) v = v + (56'sd1 <<< OUT_FRAC_BITS);
            if (v > 56'sd140737488355327) begin
                v = 56'sd140737488355327; s = 1'b1;
            end else if (v < -56'sd140737488355328) begin
                v = -56'sd140737488355328; s = 1'b1;
            end
            o_grad[k*ENTRY_W +: ENTRY_W] <= v[ENTRY_W-1:0];
        end
        o_sat <= s;
    end

endmodule

// File: hdl/three_body_gravity_gradient.sv
`timescale 1ns / 1ps
// Top level of the three-body gravity gradient pipeline.
// Depends on tbgg_pkg, tbgg_body and tbgg_entry.
//
// Usage: raise start for one cycle with a position word on i_pos_x/y/z.
// busy is tied low: the pipeline takes a new word every cycle.
// Each word yields one result word, shown for exactly one cycle while
// o_done is high, carrying the six gradient entries and o_saturated.
// Results leave in the order the words entered; the receiver cannot
// stall, so no back-pressure path exists.
// Three cascaded restoring dividers for the 1/r^3 term make up most of the
// pipeline, after a 32-stage bit-per-stage square root. Throughput is one
// word per cycle. The user must write the mass ratio register through
// i_cfg_we/i_cfg_data only while the pipeline is empty; the block itself
// does not enforce this. Reset loads the Earth-Moon value and clears all
// valid bits, so nothing is emitted until new words arrive.
module three_body_gravity_gradient import tbgg_pkg::*; #(
    parameter int POS_FRAC_BITS = 28,
    parameter int OUT_FRAC_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    output logic                o_done,
    output logic signed [47:0]  o_grad_xx,
    output logic signed [47:0]  o_grad_xy,
    output logic signed [47:0]  o_grad_xz,
    output logic signed [47:0]  o_grad_yy,
    output logic signed [47:0]  o_grad_yz,
    output logic signed [47:0]  o_grad_zz,
    output logic                o_saturated
);

    localparam int SCALE = 32 - POS_FRAC_BITS;
    // Offsets span the scaled position plus or minus one unit, with sign.
    localparam int OFF_W = 34 + SCALE;

    logic [31:0] r_mass_ratio;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mass_ratio <= 32'd52183853;
        else if (i_cfg_we) r_mass_ratio <= i_cfg_data;
    end

    assign busy = 1'b0;

    // Offsets to each primary, exact in Q.32.
    logic signed [OFF_W-1:0] w_px, w_py, w_pz, w_o1x, w_o2x;
    assign w_px  = OFF_W'(i_pos_x) <<< SCALE;
    assign w_py  = OFF_W'(i_pos_y) <<< SCALE;
    assign w_pz  = OFF_W'(i_pos_z) <<< SCALE;
    assign w_o1x = w_px + $signed({{(OFF_W-32){1'b0}}, r_mass_ratio});
    assign w_o2x = w_o1x - (OFF_W'(1) <<< 32);

    t_body w_b1, w_b2;
    tbgg_body #(.OUT_FRAC_BITS(OUT_FRAC_BITS), .OFF_W(OFF_W)) u_body1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start),
        .i_off_x(w_o1x), .i_off_y(w_py), .i_off_z(w_pz),
        .i_mass(33'h1_0000_0000 - {1'b0, r_mass_ratio}), .o_body(w_b1)
    );
    tbgg_body #(.OUT_FRAC_BITS(OUT_FRAC_BITS), .OFF_W(OFF_W)) u_body2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start),
        .i_off_x(w_o2x), .i_off_y(w_py), .i_off_z(w_pz),
        .i_mass({1'b0, r_mass_ratio}), .o_body(w_b2)
    );

    logic [6*ENTRY_W-1:0] w_grad;
    tbgg_entry #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_entry (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_b1(w_b1), .i_b2(w_b2),
        .o_valid(o_done), .o_grad(w_grad), .o_sat(o_saturated)
    );

    assign o_grad_xx = w_grad[0*ENTRY_W +: ENTRY_W];
    assign o_grad_xy = w_grad[1*ENTRY_W +: ENTRY_W];
    assign o_grad_xz = w_grad[2*ENTRY_W +: ENTRY_W];
    assign o_grad_yy = w_grad[3*ENTRY_W +: ENTRY_W];
    assign o_grad_yz = w_grad[4*ENTRY_W +: ENTRY_W];
    assign o_grad_zz = w_grad[5*ENTRY_W +: ENTRY_W];

    // Both primaries run in lockstep, so their valid bits must agree.
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_b1.valid == w_b2.valid) else $error("primary pipelines out of step");
    // A primary with zero distance always flags saturation.
    a_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b1.valid && !w_b1.have) |-> w_b1.clip) else $error("zero distance unflagged");
    // The block never reports busy.
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy asserted");

endmodule
